[hdl/bilinear_image_scaler_unit_assert.svh]
// ----------------------------------------------------------------------------
// Bilinear image scaler assertion macros
// Shared property forms for the checker of the bilinear image scaler.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent, outside reset.
`define BIS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent, outside reset.
`define BIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent, reset included.
`define BIS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/bis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Field widths, register codes and defaults shared by the scaler and its
// checker.
// ----------------------------------------------------------------------------
package bis_pkg;

    // Payload field widths.
    localparam int COORD_W = 9;
    localparam int PIX_W   = 8;
    localparam int CMD_W   = 1;

    // Scale factors are unsigned Q2.16.
    localparam int SCALE_W    = 18;
    localparam int SCALE_FRAC = 16;
    localparam int FRAC_W     = 8;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd45875;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_X = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Y = 4'd1;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

    // Default source frame size.
    localparam int SRC_WIDTH_DEF  = 400;
    localparam int SRC_HEIGHT_DEF = 300;

endpackage

[hdl/bilinear_image_scaler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Frame store of 8-bit source pixels and a seven-stage bilinear resampler.
// ----------------------------------------------------------------------------
// The block accepts one request per clock, pixel writes and interpolation
// requests alike, and delivers one interpolated pixel per clock while the
// result side is not stalled. Each read passes seven register stages, the
// frame store read among them: the store is split into an even-column bank
// and an odd-column bank, each with one write port and two registered read
// ports, so the four neighbors of a sample are fetched in the same cycle.
// Writes and reads reach the store in the same pipeline stage and in
// arrival order, so a request always sees every write accepted before it.
// The store has no reset and no clearing pass: a pixel that was never
// written reads as an undefined value. Stalls on the result side only hold
// the pipeline once all of its stages are occupied.
module bilinear_image_scaler_unit #(
    parameter int SRC_WIDTH  = bis_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = bis_pkg::SRC_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bis_pkg::SCALE_W-1:0]     cfg_data,
    // Input request channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bis_pkg::CMD_W-1:0]       s_command,
    input  logic [bis_pkg::COORD_W-1:0]     s_column,
    input  logic [bis_pkg::COORD_W-1:0]     s_row,
    input  logic [bis_pkg::PIX_W-1:0]       s_pixel_in,
    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bis_pkg::PIX_W-1:0]       m_pixel_out
);

    localparam int XW     = $clog2(SRC_WIDTH);
    localparam int YW     = $clog2(SRC_HEIGHT);
    localparam int HALF   = (SRC_WIDTH + 1) / 2;
    localparam int HW     = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int DEPTH  = HALF * SRC_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int PROD_W = bis_pkg::COORD_W + bis_pkg::SCALE_W;
    localparam int IP_W   = PROD_W - bis_pkg::SCALE_FRAC;
    localparam int FW     = bis_pkg::FRAC_W;
    localparam int PW     = bis_pkg::PIX_W;
    localparam int WT_W   = FW + 1;
    localparam int HB_W   = PW + FW;
    localparam int SUM_W  = HB_W + FW;

    localparam logic [XW-1:0] LAST_X = XW'(SRC_WIDTH - 1);
    localparam logic [YW-1:0] LAST_Y = YW'(SRC_HEIGHT - 1);
    localparam logic [WT_W-1:0] WT_ONE = WT_W'(1 << FW);

    // Frame store banks, even and odd source columns.
    logic [PW-1:0] mem_even [DEPTH];
    logic [PW-1:0] mem_odd  [DEPTH];

    // Scale registers.
    logic [bis_pkg::SCALE_W-1:0] scale_x_reg;
    logic [bis_pkg::SCALE_W-1:0] scale_y_reg;

    // Stage enables.
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;
    logic wr_fire;

    // Stage A: accepted request.
    logic                        a_valid_reg;
    logic [bis_pkg::CMD_W-1:0]   a_cmd_reg;
    logic [bis_pkg::COORD_W-1:0] a_col_reg;
    logic [bis_pkg::COORD_W-1:0] a_row_reg;
    logic [PW-1:0]               a_pix_reg;

    // Stage B: scaled positions.
    logic                        b_valid_reg;
    logic [bis_pkg::CMD_W-1:0]   b_cmd_reg;
    logic [bis_pkg::COORD_W-1:0] b_col_reg;
    logic [bis_pkg::COORD_W-1:0] b_row_reg;
    logic [PW-1:0]               b_pix_reg;
    logic                        b_in_frame_reg;
    logic                        b_in_frame_next;
    logic [PROD_W-1:0]           b_pos_x_reg;
    logic [PROD_W-1:0]           b_pos_x_next;
    logic [PROD_W-1:0]           b_pos_y_reg;
    logic [PROD_W-1:0]           b_pos_y_next;

    // Stage C: clamped neighbor coordinates and fractions.
    logic                        c_valid_reg;
    logic [bis_pkg::CMD_W-1:0]   c_cmd_reg;
    logic [PW-1:0]               c_pix_reg;
    logic                        c_in_frame_reg;
    logic [XW-1:0]               c_x0_reg, c_x0_next;
    logic [XW-1:0]               c_x1_reg, c_x1_next;
    logic [YW-1:0]               c_y0_reg, c_y0_next;
    logic [YW-1:0]               c_y1_reg, c_y1_next;
    logic [FW-1:0]               c_fx_reg;
    logic [FW-1:0]               c_fy_reg;
    logic [IP_W-1:0]             ip_x;
    logic [IP_W-1:0]             ip_y;
    logic [XW-1:0]               x0_clamp;
    logic [YW-1:0]               y0_clamp;

    // Stage D: bank addresses.
    logic                        d_valid_reg;
    logic [bis_pkg::CMD_W-1:0]   d_cmd_reg;
    logic [PW-1:0]               d_pix_reg;
    logic                        d_in_frame_reg;
    logic                        d_sel1_reg;
    logic                        d_sel2_reg;
    logic [FW-1:0]               d_fx_reg;
    logic [FW-1:0]               d_fy_reg;
    logic [AW-1:0]               d_e0_reg, d_e0_next;
    logic [AW-1:0]               d_e1_reg, d_e1_next;
    logic [AW-1:0]               d_o0_reg, d_o0_next;
    logic [AW-1:0]               d_o1_reg, d_o1_next;
    logic [XW-1:0]               x_even;
    logic [XW-1:0]               x_odd;
    logic [HW-1:0]               h_even;
    logic [HW-1:0]               h_odd;

    // Stage E: read data of both banks.
    logic                        e_valid_reg;
    logic                        e_sel1_reg;
    logic                        e_sel2_reg;
    logic [FW-1:0]               e_fx_reg;
    logic [FW-1:0]               e_fy_reg;
    logic [PW-1:0]               q_e0_reg, q_e1_reg, q_o0_reg, q_o1_reg;

    // Stage F: horizontal blends of the upper and lower rows.
    logic                        f_valid_reg;
    logic [FW-1:0]               f_fy_reg;
    logic [HB_W-1:0]             f_top_reg, f_top_next;
    logic [HB_W-1:0]             f_bot_reg, f_bot_next;
    logic [PW-1:0]               v1, v2, v3, v4;
    logic [WT_W-1:0]             wx;

    // Stage G: output register.
    logic                        m_valid_reg;
    logic [PW-1:0]               m_pixel_reg, m_pixel_next;
    logic [SUM_W-1:0]            sum_v;
    logic [WT_W-1:0]             wy;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= bis_pkg::SCALE_RESET;
            scale_y_reg <= bis_pkg::SCALE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bis_pkg::REG_SCALE_X: scale_x_reg <= cfg_data;
                bis_pkg::REG_SCALE_Y: scale_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    assign en_g    = !m_valid_reg || m_ready;
    assign en_f    = !f_valid_reg || en_g;
    assign en_e    = !e_valid_reg || en_f;
    assign en_d    = !d_valid_reg || en_e;
    assign en_c    = !c_valid_reg || en_d;
    assign en_b    = !b_valid_reg || en_c;
    assign en_a    = !a_valid_reg || en_b;
    assign s_ready = en_a;

    // An in-frame pixel write commits when it leaves the address stage.
    assign wr_fire = en_e && d_valid_reg && (d_cmd_reg == bis_pkg::CMD_WRITE) && d_in_frame_reg;

    // Valid flags of the stages. Writes leave the pipeline at the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= s_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
            if (en_d) d_valid_reg <= c_valid_reg;
            if (en_e) e_valid_reg <= d_valid_reg && (d_cmd_reg == bis_pkg::CMD_READ);
            if (en_f) f_valid_reg <= e_valid_reg;
            if (en_g) m_valid_reg <= f_valid_reg;
        end
    end

    // Stage B: scale both coordinates and check writes against the frame.
    always_comb begin
        b_pos_x_next    = PROD_W'(a_col_reg) * PROD_W'(scale_x_reg);
        b_pos_y_next    = PROD_W'(a_row_reg) * PROD_W'(scale_y_reg);
        b_in_frame_next = (32'(a_col_reg) < 32'(SRC_WIDTH))
                       && (32'(a_row_reg) < 32'(SRC_HEIGHT));
    end

    // Stage C: integer position clamped to the last column or row, with the
    // right and lower neighbors replicating the edge. Writes carry their own
    // coordinates in the upper-left slot.
    always_comb begin
        ip_x     = b_pos_x_reg[PROD_W-1:bis_pkg::SCALE_FRAC];
        ip_y     = b_pos_y_reg[PROD_W-1:bis_pkg::SCALE_FRAC];
        x0_clamp = (32'(ip_x) > 32'(SRC_WIDTH - 1)) ? LAST_X : XW'(ip_x);
        y0_clamp = (32'(ip_y) > 32'(SRC_HEIGHT - 1)) ? LAST_Y : YW'(ip_y);
        if (b_cmd_reg == bis_pkg::CMD_WRITE) begin
            c_x0_next = XW'(b_col_reg);
            c_y0_next = YW'(b_row_reg);
        end else begin
            c_x0_next = x0_clamp;
            c_y0_next = y0_clamp;
        end
        c_x1_next = (c_x0_next == LAST_X) ? c_x0_next : c_x0_next + XW'(1);
        c_y1_next = (c_y0_next == LAST_Y) ? c_y0_next : c_y0_next + YW'(1);
    end

    // Stage D: each bank serves the neighbor column of its parity.
    always_comb begin
        x_even    = c_x0_reg[0] ? c_x1_reg : c_x0_reg;
        x_odd     = c_x0_reg[0] ? c_x0_reg : c_x1_reg;
        h_even    = HW'(x_even >> 1);
        h_odd     = HW'(x_odd >> 1);
        d_e0_next = AW'(c_y0_reg) * AW'(HALF) + AW'(h_even);
        d_e1_next = AW'(c_y1_reg) * AW'(HALF) + AW'(h_even);
        d_o0_next = AW'(c_y0_reg) * AW'(HALF) + AW'(h_odd);
        d_o1_next = AW'(c_y1_reg) * AW'(HALF) + AW'(h_odd);
    end

    // Frame store: both ports of both banks read in the same stage where
    // writes land, so accesses stay in request order and never overlap.
    always_ff @(posedge aclk) begin
        if (en_e) begin
            q_e0_reg <= mem_even[d_e0_reg];
            q_e1_reg <= mem_even[d_e1_reg];
            q_o0_reg <= mem_odd[d_o0_reg];
            q_o1_reg <= mem_odd[d_o1_reg];
        end
        if (wr_fire) begin
            if (d_sel1_reg) begin
                mem_odd[d_o0_reg] <= d_pix_reg;
            end else begin
                mem_even[d_e0_reg] <= d_pix_reg;
            end
        end
    end

    // Stage F: pick the four neighbors and blend each row horizontally.
    always_comb begin
        v1         = e_sel1_reg ? q_o0_reg : q_e0_reg;
        v2         = e_sel2_reg ? q_o0_reg : q_e0_reg;
        v3         = e_sel1_reg ? q_o1_reg : q_e1_reg;
        v4         = e_sel2_reg ? q_o1_reg : q_e1_reg;
        wx         = WT_ONE - WT_W'(e_fx_reg);
        f_top_next = HB_W'((HB_W + 1)'(v1) * (HB_W + 1)'(wx)
                         + (HB_W + 1)'(v2) * (HB_W + 1)'(e_fx_reg));
        f_bot_next = HB_W'((HB_W + 1)'(v3) * (HB_W + 1)'(wx)
                         + (HB_W + 1)'(v4) * (HB_W + 1)'(e_fx_reg));
    end

    // Stage G: vertical blend. The weighted sum never exceeds 255 in its
    // integer part, so the truncated integer bits are already in range.
    always_comb begin
        wy           = WT_ONE - WT_W'(f_fy_reg);
        sum_v        = SUM_W'(f_top_reg) * SUM_W'(wy) + SUM_W'(f_bot_reg) * SUM_W'(f_fy_reg);
        m_pixel_next = sum_v[SUM_W-1:SUM_W-PW];
    end

    // Payload registers of all stages.
    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_cmd_reg <= s_command;
            a_col_reg <= s_column;
            a_row_reg <= s_row;
            a_pix_reg <= s_pixel_in;
        end
        if (en_b) begin
            b_cmd_reg      <= a_cmd_reg;
            b_col_reg      <= a_col_reg;
            b_row_reg      <= a_row_reg;
            b_pix_reg      <= a_pix_reg;
            b_in_frame_reg <= b_in_frame_next;
            b_pos_x_reg    <= b_pos_x_next;
            b_pos_y_reg    <= b_pos_y_next;
        end
        if (en_c) begin
            c_cmd_reg      <= b_cmd_reg;
            c_pix_reg      <= b_pix_reg;
            c_in_frame_reg <= b_in_frame_reg;
            c_x0_reg       <= c_x0_next;
            c_x1_reg       <= c_x1_next;
            c_y0_reg       <= c_y0_next;
            c_y1_reg       <= c_y1_next;
            c_fx_reg       <= b_pos_x_reg[bis_pkg::SCALE_FRAC-1:bis_pkg::SCALE_FRAC-FW];
            c_fy_reg       <= b_pos_y_reg[bis_pkg::SCALE_FRAC-1:bis_pkg::SCALE_FRAC-FW];
        end
        if (en_d) begin
            d_cmd_reg      <= c_cmd_reg;
            d_pix_reg      <= c_pix_reg;
            d_in_frame_reg <= c_in_frame_reg;
            d_sel1_reg     <= c_x0_reg[0];
            d_sel2_reg     <= c_x1_reg[0];
            d_fx_reg       <= c_fx_reg;
            d_fy_reg       <= c_fy_reg;
            d_e0_reg       <= d_e0_next;
            d_e1_reg       <= d_e1_next;
            d_o0_reg       <= d_o0_next;
            d_o1_reg       <= d_o1_next;
        end
        if (en_e) begin
            e_sel1_reg <= d_sel1_reg;
            e_sel2_reg <= d_sel2_reg;
            e_fx_reg   <= d_fx_reg;
            e_fy_reg   <= d_fy_reg;
        end
        if (en_f) begin
            f_fy_reg  <= e_fy_reg;
            f_top_reg <= f_top_next;
            f_bot_reg <= f_bot_next;
        end
        if (en_g) begin
            m_pixel_reg <= m_pixel_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_reg;

endmodule

[hdl/bis_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler checker
// Port-level assertions on reset, flow control and result stability.
// ----------------------------------------------------------------------------
`include "bilinear_image_scaler_unit_assert.svh"

module bis_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bis_pkg::SCALE_W-1:0]     cfg_data,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [bis_pkg::CMD_W-1:0]       s_command,
    input logic [bis_pkg::COORD_W-1:0]     s_column,
    input logic [bis_pkg::COORD_W-1:0]     s_row,
    input logic [bis_pkg::PIX_W-1:0]       s_pixel_in,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [bis_pkg::PIX_W-1:0]       m_pixel_out
);

    // Right after reset the pipeline is empty and takes requests.
    `BIS_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn), !m_valid && s_ready, "pipeline not empty after reset")

    // Configuration writes are never refused.
    `BIS_ASSERT_ALWAYS(a_cfg_ready, aclk, 1'b1, cfg_ready, "configuration port refused a write")

    // When the result side can move, the input side must move as well.
    `BIS_ASSERT_SAME(a_ready_flow, aclk, aresetn, !m_valid || m_ready, s_ready, "input stalled while output is free")

    // A stalled result keeps its value.
    `BIS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pixel_out), "stalled result changed")

endmodule

bind bilinear_image_scaler_unit bis_checker u_bis_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler testbench
// Writes source pixels and sends interpolation requests through the input
// channel, mirrors the frame store and both scale factors in a local model,
// and compares every returned pixel with the predicted blend. Directed tests
// cover the corners, ignored writes, the scale extremes and edge
// replication. Random traffic follows, with random stalls on both sides, a
// long stall on the result side and pauses that drain the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SRC_W          = bis_pkg::SRC_WIDTH_DEF;
    localparam int SRC_H          = bis_pkg::SRC_HEIGHT_DEF;
    localparam int PIPE_LATENCY   = 6;
    localparam int DRAIN_CYCLES   = 2 * PIPE_LATENCY + 2;
    localparam int IDLE_LIMIT     = 5000;
    localparam int RANDOM_ITEMS   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam logic [bis_pkg::SCALE_W-1:0] UNIT_SCALE = 18'h10000;
    localparam logic [bis_pkg::SCALE_W-1:0] MAX_SCALE  = 18'h3FFFF;

    typedef struct packed {
        logic [bis_pkg::PIX_W-1:0]   pixel;
        logic [bis_pkg::COORD_W-1:0] column;
        logic [bis_pkg::COORD_W-1:0] row;
    } pending_pixel_t;

    logic                            aclk       = 1'b0;
    logic                            aresetn    = 1'b0;
    logic                            cfg_valid  = 1'b0;
    logic                            cfg_ready;
    logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [bis_pkg::SCALE_W-1:0]     cfg_data   = '0;
    logic                            s_valid    = 1'b0;
    logic                            s_ready;
    logic [bis_pkg::CMD_W-1:0]       s_command  = bis_pkg::CMD_WRITE;
    logic [bis_pkg::COORD_W-1:0]     s_column   = '0;
    logic [bis_pkg::COORD_W-1:0]     s_row      = '0;
    logic [bis_pkg::PIX_W-1:0]       s_pixel_in = '0;
    logic                            m_valid;
    logic                            m_ready    = 1'b0;
    logic [bis_pkg::PIX_W-1:0]       m_pixel_out;

    // Local copy of the block's state.
    logic [bis_pkg::PIX_W-1:0]   frame_mem [SRC_W*SRC_H];
    bit                          pixel_written [SRC_W*SRC_H];
    logic [bis_pkg::SCALE_W-1:0] scale_x_q = bis_pkg::SCALE_RESET;
    logic [bis_pkg::SCALE_W-1:0] scale_y_q = bis_pkg::SCALE_RESET;
    pending_pixel_t              pending_pixels [$];

    int mismatch_count   = 0;
    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    int hold_request     = 0;
    int hold_left        = 0;
    int ready_gap        = 0;

    bilinear_image_scaler_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_column    (s_column),
        .s_row       (s_row),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int store_index(input int column, input int row);
        return row * SRC_W + column;
    endfunction

    // Scales one destination coordinate and returns the clamped pair of source
    // indexes with the 8-bit fraction between them.
    function automatic void map_source(input logic [bis_pkg::COORD_W-1:0] dst,
                                       input logic [bis_pkg::SCALE_W-1:0] scale,
                                       input int last,
                                       output int lo, output int hi,
                                       output logic [bis_pkg::FRAC_W-1:0] frac);
        logic [bis_pkg::COORD_W+bis_pkg::SCALE_W-1:0] pos;
        int                                           ipart;
        pos   = dst * scale;
        ipart = int'(pos[bis_pkg::COORD_W+bis_pkg::SCALE_W-1:bis_pkg::SCALE_FRAC]);
        frac  = pos[bis_pkg::SCALE_FRAC-1:bis_pkg::SCALE_FRAC-bis_pkg::FRAC_W];
        lo    = (ipart > last) ? last : ipart;
        hi    = (lo >= last) ? last : lo + 1;
    endfunction

    // Blends the four source neighbors of a destination pixel.
    function automatic logic [bis_pkg::PIX_W-1:0] predict_pixel(
            input logic [bis_pkg::COORD_W-1:0] column,
            input logic [bis_pkg::COORD_W-1:0] row);
        int                         x0, x1, y0, y1;
        int                         wx, wy, fxi, fyi;
        logic [bis_pkg::FRAC_W-1:0] fx, fy;
        int                         blend;
        map_source(column, scale_x_q, SRC_W - 1, x0, x1, fx);
        map_source(row, scale_y_q, SRC_H - 1, y0, y1, fy);
        fxi   = int'(fx);
        fyi   = int'(fy);
        wx    = 256 - fxi;
        wy    = 256 - fyi;
        blend = int'(frame_mem[store_index(x0, y0)]) * wx * wy
              + int'(frame_mem[store_index(x1, y0)]) * fxi * wy
              + int'(frame_mem[store_index(x0, y1)]) * wx * fyi
              + int'(frame_mem[store_index(x1, y1)]) * fxi * fyi;
        blend = blend >>> 16;
        if (blend > 255) begin
            blend = 255;
        end
        return bis_pkg::PIX_W'(blend);
    endfunction

    // Sends one request and updates the model once it is accepted. The valid
    // line stays high when the next request follows without a gap.
    task automatic send_request(input logic [bis_pkg::CMD_W-1:0] command,
                                input logic [bis_pkg::COORD_W-1:0] column,
                                input logic [bis_pkg::COORD_W-1:0] row,
                                input logic [bis_pkg::PIX_W-1:0] pixel);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= command;
        s_column   <= column;
        s_row      <= row;
        s_pixel_in <= pixel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (command == bis_pkg::CMD_WRITE) begin
            if (column < SRC_W && row < SRC_H) begin
                frame_mem[store_index(column, row)]     = pixel;
                pixel_written[store_index(column, row)] = 1'b1;
            end
        end else begin
            pending_pixels.push_back('{pixel: predict_pixel(column, row),
                                       column: column, row: row});
        end
    endtask

    task automatic write_pixel(input int column, input int row,
                               input logic [bis_pkg::PIX_W-1:0] pixel);
        send_request(bis_pkg::CMD_WRITE, bis_pkg::COORD_W'(column),
                     bis_pkg::COORD_W'(row), pixel);
    endtask

    // Writes every neighbor that a request would read and that holds no value
    // yet, or all of them when refresh is set.
    task automatic ensure_neighbors(input logic [bis_pkg::COORD_W-1:0] column,
                                    input logic [bis_pkg::COORD_W-1:0] row,
                                    input bit refresh, output int writes);
        int                         xs [2];
        int                         ys [2];
        logic [bis_pkg::FRAC_W-1:0] frac;
        map_source(column, scale_x_q, SRC_W - 1, xs[0], xs[1], frac);
        map_source(row, scale_y_q, SRC_H - 1, ys[0], ys[1], frac);
        writes = 0;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++) begin
                if (refresh || !pixel_written[store_index(xs[i], ys[j])]) begin
                    write_pixel(xs[i], ys[j], bis_pkg::PIX_W'($urandom_range(0, 255)));
                    writes++;
                end
            end
        end
    endtask

    task automatic request_pixel(input int column, input int row);
        int writes;
        ensure_neighbors(bis_pkg::COORD_W'(column), bis_pkg::COORD_W'(row), 1'b0, writes);
        send_request(bis_pkg::CMD_READ, bis_pkg::COORD_W'(column), bis_pkg::COORD_W'(row),
                     bis_pkg::PIX_W'($urandom_range(0, 255)));
    endtask

    // Waits until every predicted pixel has come back, then lets writes that
    // are still in flight settle.
    task automatic wait_idle();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() > 0 && waited < IDLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_pixels.size() > 0) begin
            report_mismatch($sformatf("%0d predicted pixels never returned",
                                      pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [bis_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [bis_pkg::SCALE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            bis_pkg::REG_SCALE_X: scale_x_q = value;
            bis_pkg::REG_SCALE_Y: scale_y_q = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_scales(input logic [bis_pkg::SCALE_W-1:0] sx,
                              input logic [bis_pkg::SCALE_W-1:0] sy);
        wait_idle();
        write_register(bis_pkg::REG_SCALE_X, sx);
        write_register(bis_pkg::REG_SCALE_Y, sy);
    endtask

    function automatic logic [bis_pkg::SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return MAX_SCALE;
            2: return UNIT_SCALE;
            3: return bis_pkg::SCALE_RESET;
            4: return bis_pkg::SCALE_W'($urandom_range(0, 2 * UNIT_SCALE));
            default: return bis_pkg::SCALE_W'($urandom());
        endcase
    endfunction

    // Result side: random stalls per result, a long stall on demand, and a
    // comparison of each accepted pixel with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d returned with no request pending",
                                              m_pixel_out));
                end else if (m_pixel_out !== pending_pixels[0].pixel) begin
                    report_mismatch($sformatf("column %0d row %0d: got %0d, predicted %0d",
                                              pending_pixels[0].column, pending_pixels[0].row,
                                              m_pixel_out, pending_pixels[0].pixel));
                    void'(pending_pixels.pop_front());
                end else begin
                    void'(pending_pixels.pop_front());
                end
                ready_gap = receiver_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Corners at the reset scale, with the extreme pixel values.
    task automatic test_corner_pixels();
        write_pixel(0, 0, 8'd0);
        write_pixel(1, 0, 8'd255);
        write_pixel(0, 1, 8'd255);
        write_pixel(1, 1, 8'd0);
        request_pixel(0, 0);
        request_pixel(1, 1);
        request_pixel(511, 511);
    endtask

    // Writes outside the source frame must leave the store unchanged.
    task automatic test_ignored_writes();
        write_pixel(400, 0, 8'd255);
        write_pixel(0, 300, 8'd255);
        write_pixel(511, 511, 8'd255);
        request_pixel(1, 1);
    endtask

    // A zero scale maps everything onto the origin; the largest scale runs
    // past the frame and clamps onto the last column and row.
    task automatic test_scale_extremes();
        set_scales('0, '0);
        request_pixel(511, 511);
        set_scales(MAX_SCALE, MAX_SCALE);
        request_pixel(1, 1);
        request_pixel(511, 511);
        request_pixel(0, 0);
    endtask

    // At the last column and row the outer neighbor replicates the edge pixel,
    // with and without a fraction.
    task automatic test_edge_replication();
        set_scales(UNIT_SCALE, UNIT_SCALE);
        request_pixel(399, 299);
        request_pixel(399, 0);
        request_pixel(0, 299);
        set_scales(UNIT_SCALE + 18'd128, UNIT_SCALE + 18'd128);
        request_pixel(399, 299);
    endtask

    // Four full-scale neighbors with half fractions must blend back to 255.
    task automatic test_bright_blend();
        set_scales(18'h18000, 18'h18000);
        write_pixel(4, 4, 8'd255);
        write_pixel(5, 4, 8'd255);
        write_pixel(4, 5, 8'd255);
        write_pixel(5, 5, 8'd255);
        request_pixel(3, 3);
    endtask

    // The result side holds off while requests keep coming, so the pipeline
    // fills and the input stalls.
    task automatic test_backpressure();
        set_scales(UNIT_SCALE, UNIT_SCALE);
        sender_idle_on = 1'b0;
        for (int r = 0; r < 10; r++) begin
            for (int c = 0; c < 10; c++) begin
                write_pixel(c, r, bis_pkg::PIX_W'($urandom_range(0, 255)));
            end
        end
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 48; i++) begin
            request_pixel($urandom_range(0, 8), $urandom_range(0, 8));
        end
        sender_idle_on = 1'b1;
        wait_idle();
    endtask

    // One random sequence: mostly a request with its neighbors written first,
    // otherwise a plain write inside or outside the frame.
    task automatic run_random_sequence(output int items);
        int                          kind;
        int                          writes;
        logic [bis_pkg::COORD_W-1:0] column;
        logic [bis_pkg::COORD_W-1:0] row;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            if ($urandom_range(0, 3) == 0) begin
                column = bis_pkg::COORD_W'($urandom_range(0, 511));
                row    = bis_pkg::COORD_W'($urandom_range(0, 511));
            end else begin
                column = bis_pkg::COORD_W'($urandom_range(0, SRC_W - 1));
                row    = bis_pkg::COORD_W'($urandom_range(0, SRC_H - 1));
            end
            ensure_neighbors(column, row, $urandom_range(0, 2) == 0, writes);
            send_request(bis_pkg::CMD_READ, column, row,
                         bis_pkg::PIX_W'($urandom_range(0, 255)));
            items = writes + 1;
        end else if (kind < 85) begin
            write_pixel($urandom_range(0, SRC_W - 1), $urandom_range(0, SRC_H - 1),
                        bis_pkg::PIX_W'($urandom_range(0, 255)));
            items = 1;
        end else begin
            if ($urandom_range(0, 1) == 0) begin
                write_pixel($urandom_range(SRC_W, 511), $urandom_range(0, 511),
                            bis_pkg::PIX_W'($urandom_range(0, 255)));
            end else begin
                write_pixel($urandom_range(0, 511), $urandom_range(SRC_H, 511),
                            bis_pkg::PIX_W'($urandom_range(0, 255)));
            end
            items = 1;
        end
    endtask

    // The sender stops until every result is back, then carries on.
    task automatic test_drain_pause();
        int items;
        set_scales(pick_scale(), pick_scale());
        repeat (10) run_random_sequence(items);
        wait_idle();
        repeat (10) run_random_sequence(items);
    endtask

    // Random phases, each under fresh scale factors and idling choices.
    task automatic test_random_traffic();
        int counted;
        int phase;
        int items;
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            case (phase)
                0: set_scales('0, MAX_SCALE);
                1: set_scales(MAX_SCALE, '0);
                default: set_scales(pick_scale(), pick_scale());
            endcase
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            repeat (40) begin
                run_random_sequence(items);
                counted += items;
            end
            phase++;
        end
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_pixels();
        test_ignored_writes();
        test_scale_extremes();
        test_edge_replication();
        test_bright_blend();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
